FILE: hw/rtl/asc_pkg.sv
package asc_pkg;

    localparam int KeyW = 64;
    localparam int OpW = 2;
    localparam int CntW = 4;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_AD = 2'd1;
    localparam logic [1:0] OP_MSG = 2'd2;
    localparam logic [1:0] OP_FIN = 2'd3;

    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW = 2'd1;
    localparam logic [1:0] REG_DIRECTION = 2'd2;

    localparam logic [63:0] INIT_WORD = 64'h80400c0600000000;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [3:0] ROUNDS_A = 4'd12;
    localparam logic [3:0] ROUNDS_B = 4'd6;
    localparam int QueueDepth = 2;

    typedef logic [63:0] t_word;
    typedef t_word [4:0] t_state;

    typedef struct packed {
        logic [1:0] op;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [3:0] n;
    } t_item;

    typedef struct packed {
        logic [63:0] data_out;
        logic [3:0] out_bytes;
        logic [63:0] tag_high;
        logic [63:0] tag_low;
        logic status;
    } t_result;

    function automatic t_word rotr(input t_word v, input int r);
        rotr = (v >> r) | (v << (64 - r));
    endfunction

    function automatic t_state ascon_round(input t_state s, input logic [3:0] i);
        t_word x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;
        x0 = s[0]; x1 = s[1]; x2 = s[2]; x3 = s[3]; x4 = s[4];
        x2 = x2 ^ {56'd0, 4'd15 - i, i};
        x0 = x0 ^ x4; x4 = x4 ^ x3; x2 = x2 ^ x1;
        t0 = ~x0 & x1; t1 = ~x1 & x2; t2 = ~x2 & x3; t3 = ~x3 & x4; t4 = ~x4 & x0;
        x0 = x0 ^ t1; x1 = x1 ^ t2; x2 = x2 ^ t3; x3 = x3 ^ t4; x4 = x4 ^ t0;
        x1 = x1 ^ x0; x0 = x0 ^ x4; x3 = x3 ^ x2; x2 = ~x2;
        ascon_round[0] = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
        ascon_round[1] = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
        ascon_round[2] = x2 ^ rotr(x2, 1) ^ rotr(x2, 6);
        ascon_round[3] = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
        ascon_round[4] = x4 ^ rotr(x4, 7) ^ rotr(x4, 41);
    endfunction

    function automatic t_word lead_mask(input logic [3:0] n);
        lead_mask = (n == 4'd0) ? 64'd0 : (~64'd0 << (7'd64 - {n, 3'd0}));
    endfunction

    function automatic t_word pad_word(input logic [3:0] n);
        pad_word = {PAD_BYTE, 56'd0} >> {n, 3'd0};
    endfunction

endpackage

FILE: hw/rtl/asc_if.sv
interface asc_in_if;
    logic valid;
    logic ready;
    logic [1:0] operation;
    logic [63:0] word_high;
    logic [63:0] word_low;
    logic [3:0] byte_count;
    modport source(output valid, operation, word_high, word_low, byte_count, input ready);
    modport sink(input valid, operation, word_high, word_low, byte_count, output ready);
endinterface

interface asc_out_if;
    logic valid;
    logic ready;
    logic [63:0] data_out;
    logic [3:0] out_bytes;
    logic [63:0] tag_high;
    logic [63:0] tag_low;
    logic status;
    modport source(output valid, data_out, out_bytes, tag_high, tag_low, status, input ready);
    modport sink(input valid, data_out, out_bytes, tag_high, tag_low, status, output ready);
endinterface

interface asc_cfg_if;
    logic valid;
    logic ready;
    logic [1:0] index;
    logic [63:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

FILE: hw/rtl/asc_front.sv
module asc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    asc_in_if.sink              in_ch,
    output asc_pkg::t_item      o_item,
    output logic                o_valid,
    input  logic                i_pop
);
    import asc_pkg::*;

    t_item r_q [QueueDepth];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign in_ch.ready = (r_cnt != 2'd2);
    assign push = in_ch.valid && in_ch.ready;
    assign o_valid = (r_cnt != 2'd0);
    assign pop = i_pop && o_valid;
    assign o_item = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp].op <= in_ch.operation;
            r_q[r_wp].hi <= in_ch.word_high;
            r_q[r_wp].lo <= in_ch.word_low;
            r_q[r_wp].n <= in_ch.byte_count[3] ? 4'd8 : in_ch.byte_count;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
    a_nclip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_item.n <= 4'd8) else $error("byte count not clipped");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !in_ch.ready) else $error("accept while full");
`endif
endmodule

FILE: hw/rtl/asc_back.sv
module asc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  asc_pkg::t_item      i_item,
    input  logic                i_valid,
    output logic                o_pop,
    input  logic [63:0]         i_key_high,
    input  logic [63:0]         i_key_low,
    input  logic                i_dir,
    asc_out_if.source           out_ch
);
    import asc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RUN  = 3'd1;
    localparam logic [2:0] S_OUT  = 3'd2;

    localparam logic [2:0] K_NONE = 3'd0;
    localparam logic [2:0] K_INIT = 3'd1;
    localparam logic [2:0] K_ADPAD = 3'd2;
    localparam logic [2:0] K_BLOCK = 3'd3;
    localparam logic [2:0] K_FIN = 3'd4;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_AD = 2'd1;
    localparam logic [1:0] PH_MSG = 2'd2;
    localparam logic [1:0] PH_TAIL = 2'd3;

    logic [2:0] r_fsm, r_kind;
    logic [1:0] r_phase;
    logic r_ad_open, r_dec;
    logic [3:0] r_rnd, r_left;
    t_state r_s;
    t_item r_it;
    t_result r_res;
    logic r_oval;

    t_word m, blk;
    t_state s_nx;
    logic accept;

    assign m = lead_mask(r_it.n);
    assign blk = r_it.hi & m;
    assign accept = (r_fsm == S_IDLE) && i_valid && !r_oval;
    assign o_pop = accept;

    assign out_ch.valid = r_oval;
    assign out_ch.data_out = r_res.data_out;
    assign out_ch.out_bytes = r_res.out_bytes;
    assign out_ch.tag_high = r_res.tag_high;
    assign out_ch.tag_low = r_res.tag_low;
    assign out_ch.status = r_res.status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= S_IDLE;
            r_phase <= PH_IDLE;
            r_ad_open <= 1'b0;
            r_oval <= 1'b0;
            r_s <= '0;
            r_kind <= K_NONE;
            r_rnd <= 4'd0;
            r_left <= 4'd0;
        end else begin
            if (r_oval && out_ch.ready) r_oval <= 1'b0;
            case (r_fsm)
                S_IDLE: begin
                    if (accept) begin
                        r_it <= i_item;
                        r_dec <= i_dir;
                        r_res <= '0;
                        r_fsm <= S_OUT;
                    end
                end
                S_OUT: begin
                    // Decide the next step of the current item.
                    r_fsm <= S_IDLE;
                    r_kind <= K_NONE;
                    case (r_it.op)
                        OP_START: begin
                            if (r_kind == K_INIT) begin
                                r_s[3] <= r_s[3] ^ i_key_high;
                                r_s[4] <= r_s[4] ^ i_key_low;
                                r_phase <= PH_AD;
                                r_ad_open <= 1'b0;
                                r_oval <= 1'b1;
                            end else begin
                                r_s <= {r_it.lo, r_it.hi, i_key_low, i_key_high, INIT_WORD};
                                r_kind <= K_INIT; r_rnd <= 4'd0; r_left <= ROUNDS_A;
                                r_fsm <= S_RUN;
                            end
                        end
                        OP_AD: begin
                            if (r_kind == K_BLOCK) begin
                                if (r_it.n != 4'd8) begin
                                    r_s[4] <= r_s[4] ^ 64'd1;
                                    r_phase <= PH_MSG;
                                    r_ad_open <= 1'b0;
                                end else r_ad_open <= 1'b1;
                                r_oval <= 1'b1;
                            end else if (r_phase == PH_AD) begin
                                r_s[0] <= r_s[0] ^ blk ^
                                    ((r_it.n == 4'd8) ? 64'd0 : pad_word(r_it.n));
                                r_kind <= K_BLOCK; r_rnd <= 4'd6; r_left <= ROUNDS_B;
                                r_fsm <= S_RUN;
                            end else r_oval <= 1'b1;
                        end
                        default: begin
                            if (r_kind == K_ADPAD || (r_phase == PH_AD && !r_ad_open)) begin
                                r_s[4] <= r_s[4] ^ 64'd1;
                                r_phase <= PH_MSG;
                                r_ad_open <= 1'b0;
                                r_fsm <= S_OUT;
                            end else if (r_phase == PH_AD) begin
                                r_s[0] <= r_s[0] ^ pad_word(4'd0);
                                r_kind <= K_ADPAD; r_rnd <= 4'd6; r_left <= ROUNDS_B;
                                r_fsm <= S_RUN;
                            end else if (r_it.op == OP_MSG) begin
                                if (r_kind == K_BLOCK) r_oval <= 1'b1;
                                else if (r_phase == PH_MSG) begin
                                    r_res.data_out <= r_dec ? ((r_s[0] ^ blk) & m)
                                                            : ((r_s[0] ^ blk) & m);
                                    r_res.out_bytes <= r_it.n;
                                    if (r_dec) r_s[0] <= ((r_s[0] & ~m) | blk) ^
                                        ((r_it.n == 4'd8) ? 64'd0 : pad_word(r_it.n));
                                    else r_s[0] <= r_s[0] ^ blk ^
                                        ((r_it.n == 4'd8) ? 64'd0 : pad_word(r_it.n));
                                    if (r_it.n == 4'd8) begin
                                        r_kind <= K_BLOCK; r_rnd <= 4'd6;
                                        r_left <= ROUNDS_B; r_fsm <= S_RUN;
                                    end else begin
                                        r_phase <= PH_TAIL;
                                        r_oval <= 1'b1;
                                    end
                                end else r_oval <= 1'b1;
                            end else begin
                                if (r_kind == K_FIN) begin
                                    r_s[3] <= r_s[3] ^ i_key_high;
                                    r_s[4] <= r_s[4] ^ i_key_low;
                                    if (r_dec) r_res.status <=
                                        ((r_s[3] ^ i_key_high ^ r_it.hi) |
                                         (r_s[4] ^ i_key_low ^ r_it.lo)) != 64'd0;
                                    else begin
                                        r_res.tag_high <= r_s[3] ^ i_key_high;
                                        r_res.tag_low <= r_s[4] ^ i_key_low;
                                    end
                                    r_phase <= PH_IDLE;
                                    r_ad_open <= 1'b0;
                                    r_oval <= 1'b1;
                                end else if (r_phase == PH_IDLE) begin
                                    r_res.status <= r_dec;
                                    r_oval <= 1'b1;
                                end else begin
                                    r_s[0] <= r_s[0] ^ ((r_phase == PH_MSG) ?
                                        pad_word(4'd0) : 64'd0);
                                    r_s[1] <= r_s[1] ^ i_key_high;
                                    r_s[2] <= r_s[2] ^ i_key_low;
                                    r_kind <= K_FIN; r_rnd <= 4'd0; r_left <= ROUNDS_A;
                                    r_fsm <= S_RUN;
                                end
                            end
                        end
                    endcase
                end
                S_RUN: begin
                    r_s <= s_nx;
                    r_rnd <= r_rnd + 4'd1;
                    r_left <= r_left - 4'd1;
                    if (r_left == 4'd1) r_fsm <= S_OUT;
                end
                default: r_fsm <= S_IDLE;
            endcase
        end
    end

    assign s_nx = ascon_round(r_s, r_rnd);

`ifndef NO_ASSERTIONS
    a_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_RUN) |-> (r_left != 4'd0)) else $error("round counter empty");
    a_nopop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !r_oval) else $error("item taken with result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oval && !out_ch.ready) |=> r_oval) else $error("result dropped");
`endif
endmodule

FILE: hw/rtl/ascon_aead_encrypt_decrypt_top.sv
// An item's result is valid once the item, taken into an idle core, has passed the
// decision state, run any permutation rounds and come back to the decision state: start
// and finalize run 12 rounds, a full block 6. Closing associated data that ended on a full
// block adds a 6-round padding permutation, and domain separation adds a decision step.
// The core takes one item at a time; a two-entry input queue accepts items while it is busy.
// Synchronous active-low reset clears the state, phase, keys and direction.
module ascon_aead_encrypt_decrypt_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    asc_in_if.sink     in_ch,
    asc_out_if.source  out_ch,
    asc_cfg_if.sink    cfg_ch
);
    import asc_pkg::*;

    logic [63:0] r_key_high, r_key_low;
    logic r_dir;
    t_item q_item;
    logic q_valid, q_pop;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low <= '0;
            r_dir <= 1'b0;
        end else if (cfg_ch.valid) begin
            case (cfg_ch.index)
                REG_KEY_HIGH: r_key_high <= cfg_ch.data;
                REG_KEY_LOW: r_key_low <= cfg_ch.data;
                REG_DIRECTION: r_dir <= cfg_ch.data[0];
                default: ;
            endcase
        end
    end

    asc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .o_item(q_item), .o_valid(q_valid), .i_pop(q_pop)
    );

    asc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(q_item), .i_valid(q_valid),
        .o_pop(q_pop), .i_key_high(r_key_high), .i_key_low(r_key_low),
        .i_dir(r_dir), .out_ch(out_ch)
    );
endmodule
